[hdl/dqc_pkg.sv]
// Shared types, constants and the verdict function of the DNS query classifier.
// No dependencies; the parser, the top level and the checker refer to it by scoped names.
`default_nettype none

package dqc_pkg;

  // Input transaction codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_COUNTER = 1'b1;

  // Configuration register indexes
  localparam logic REG_QUERY_PORT = 1'b0;
  localparam logic REG_QUEUE_MASK = 1'b1;

  // Verdict codes
  localparam logic [2:0] VERDICT_NOT_IPV4   = 3'd0;
  localparam logic [2:0] VERDICT_NOT_UDP    = 3'd1;
  localparam logic [2:0] VERDICT_WRONG_PORT = 3'd2;
  localparam logic [2:0] VERDICT_MALFORMED  = 3'd3;
  localparam logic [2:0] VERDICT_NOT_QUERY  = 3'd4;
  localparam logic [2:0] VERDICT_QUERY      = 3'd5;

  // Statistics counter store
  localparam int         CNT_DEPTH = 8;
  localparam int         CNT_AW    = 3;
  localparam int         CNT_W     = 64;
  localparam logic [2:0] CNT_TOTAL = 3'd0;
  localparam logic [2:0] CNT_NONE  = 3'd7;

  // Frame layout (byte offsets, 7-bit position space)
  localparam logic [6:0] BYTE_MAX     = 7'd127;
  localparam logic [6:0] POS_ETYPE_HI = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO = 7'd13;
  localparam logic [6:0] POS_VER_IHL  = 7'd14;
  localparam logic [6:0] POS_FRAG_HI  = 7'd20;
  localparam logic [6:0] POS_FRAG_LO  = 7'd21;
  localparam logic [6:0] POS_PROTO    = 7'd23;
  localparam logic [6:0] ETH_LEN      = 7'd14;
  localparam logic [6:0] UDP_LEN      = 7'd8;
  localparam logic [6:0] ETH_IP_LEN   = 7'd34;
  localparam logic [6:0] UDP_END      = 7'd22;
  localparam logic [6:0] DNS_END      = 7'd34;
  localparam logic [6:0] QNAME_END    = 7'd35;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] FRAG_MASK      = 16'h2000 | 16'h1FFF;
  localparam logic [15:0] QUERY_PORT_RST = 16'd53;
  localparam logic [15:0] ONE_QUESTION   = 16'd1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [5:0] queue_index;
    logic [2:0] counter_select;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  verdict;
    logic        redirect;
    logic [5:0]  target_queue;
    logic [63:0] counter_value;
  } out_item_t;

  // Header fields of one frame as seen after its last byte
  typedef struct packed {
    logic [6:0]  len;
    logic [15:0] ether_type;
    logic [7:0]  version_and_ihl;
    logic [7:0]  ip_protocol;
    logic [15:0] fragment_field;
    logic [15:0] destination_port;
    logic [7:0]  query_flags_high;
    logic [15:0] question_count;
  } frame_t;

  // First failing check decides. An IP header longer than 60 bytes cannot
  // be encoded in four IHL bits, so that check is left out.
  function automatic logic [2:0] classify(frame_t f, logic [15:0] query_port);
    logic [6:0] h;
    logic [2:0] v;
    h = {1'b0, f.version_and_ihl[3:0], 2'b00};
    if (f.len < ETH_LEN) v = VERDICT_MALFORMED;
    else if (f.ether_type != ETHERTYPE_IPV4) v = VERDICT_NOT_IPV4;
    else if (f.len < ETH_IP_LEN) v = VERDICT_MALFORMED;
    else if (f.version_and_ihl[7:4] != IP_VERSION_4 || f.version_and_ihl[3:0] < IHL_MIN)
      v = VERDICT_MALFORMED;
    else if (f.ip_protocol != PROTO_UDP) v = VERDICT_NOT_UDP;
    else if ((f.fragment_field & FRAG_MASK) != 16'd0) v = VERDICT_MALFORMED;
    else if (f.len < UDP_END + h) v = VERDICT_MALFORMED;
    else if (f.destination_port != query_port) v = VERDICT_WRONG_PORT;
    else if (f.len < DNS_END + h) v = VERDICT_MALFORMED;
    else if (f.query_flags_high[7]) v = VERDICT_NOT_QUERY;
    else if (f.question_count != ONE_QUESTION) v = VERDICT_NOT_QUERY;
    else if (f.len < QNAME_END + h) v = VERDICT_MALFORMED;
    else v = VERDICT_QUERY;
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/dqc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dqc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/dqc_parser.sv]
// Byte-serial header capture for the DNS query classifier.
// Depends on dqc_pkg for the frame layout and the frame_t struct.
`default_nettype none

module dqc_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic          last_byte,
  input  wire logic [7:0]    data_byte,
  output dqc_pkg::frame_t    frame
);

  dqc_pkg::frame_t cur;
  logic [6:0]      pos;
  logic [6:0]      udp;
  logic [6:0]      dns;

  // Offsets follow the IHL held before this byte
  always_comb begin
    pos = cur.len;
    udp = dqc_pkg::ETH_LEN + {1'b0, cur.version_and_ihl[3:0], 2'b00};
    dns = udp + dqc_pkg::UDP_LEN;
    frame = cur;
    frame.len = (cur.len < dqc_pkg::BYTE_MAX) ? cur.len + 7'd1 : dqc_pkg::BYTE_MAX;
    if (pos == dqc_pkg::POS_ETYPE_HI) frame.ether_type[15:8] = data_byte;
    if (pos == dqc_pkg::POS_ETYPE_LO) frame.ether_type[7:0] = data_byte;
    if (pos == dqc_pkg::POS_VER_IHL)  frame.version_and_ihl = data_byte;
    if (pos == dqc_pkg::POS_FRAG_HI)  frame.fragment_field[15:8] = data_byte;
    if (pos == dqc_pkg::POS_FRAG_LO)  frame.fragment_field[7:0] = data_byte;
    if (pos == dqc_pkg::POS_PROTO)    frame.ip_protocol = data_byte;
    if (pos == udp + 7'd2) frame.destination_port[15:8] = data_byte;
    if (pos == udp + 7'd3) frame.destination_port[7:0] = data_byte;
    if (pos == dns + 7'd2) frame.query_flags_high = data_byte;
    if (pos == dns + 7'd4) frame.question_count[15:8] = data_byte;
    if (pos == dns + 7'd5) frame.question_count[7:0] = data_byte;
  end

  // Advance on each frame byte; drop everything after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (take) begin
      cur <= last_byte ? '0 : frame;
    end
  end

endmodule

`default_nettype wire

[hdl/dns_query_packet_classifier.sv]
// Top level of the DNS query classifier: header capture, verdict and counters.
// Depends on dqc_pkg, dqc_parser and dqc_ram.
`default_nettype none

// Usage
//   Input channel (in_valid / in_stall / in_data): one transaction per frame
//   byte, or a statistics read. A byte transaction with last_byte set closes
//   the frame and produces one verdict result; a read produces one counter
//   result; other byte transactions produce nothing.
//   Output channel (out_valid / out_stall / out_data): results in input order.
//   Configuration (cfg_write / cfg_index / cfg_data): query port and the
//   bound-queue mask, written while the block is idle.
// Timing
//   One transaction per clock cycle while the output is not stalled. A result
//   reaches the output register through the stage 1 and stage 2 registers:
//   stage 1 classifies and issues the counter read, stage 2 updates the
//   counter. Each frame performs one read-modify-write of its verdict counter
//   in the counter RAM (one write port, one read port); the total sits in a
//   register. Back-to-back updates of the same counter forward the value
//   just written.
// Reset
//   Clears the frame in progress, the pipeline and the counters (per-entry
//   valid bits make unwritten counters read as zero); no clearing pass.
// Stall
//   While the output holds a result and out_stall is high, the whole pipeline
//   holds and in_stall is raised in the same cycle.

module dns_query_packet_classifier #(
  parameter int NUM_QUEUES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dqc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dqc_pkg::out_item_t      out_data,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [63:0]        cfg_data
);

  // Configuration registers
  logic [15:0] query_port;
  logic [63:0] queue_bound_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_port       <= dqc_pkg::QUERY_PORT_RST;
      queue_bound_mask <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dqc_pkg::REG_QUERY_PORT: query_port       <= cfg_data[15:0];
        dqc_pkg::REG_QUEUE_MASK: queue_bound_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: the output register is free or being drained
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic accept;
  logic take_byte;
  assign accept    = in_valid && en;
  assign take_byte = accept && (in_data.action == dqc_pkg::ACT_BYTE);

  // Stage 0: header capture
  dqc_pkg::frame_t cap_frame;

  dqc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take_byte),
    .last_byte (in_data.last_byte),
    .data_byte (in_data.data_byte),
    .frame     (cap_frame)
  );

  // Stage 1: classify and issue the counter read
  logic            s1_valid;
  logic            s1_kind;
  dqc_pkg::frame_t s1_frame;
  logic [5:0]      s1_queue;
  logic [2:0]      s1_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid &&
                  (in_data.action == dqc_pkg::ACT_READ || in_data.last_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind  <= (in_data.action == dqc_pkg::ACT_READ) ? dqc_pkg::KIND_COUNTER
                                                        : dqc_pkg::KIND_VERDICT;
      s1_frame <= cap_frame;
      s1_queue <= in_data.queue_index;
      s1_sel   <= in_data.counter_select;
    end
  end

  logic [2:0]               s1_verdict;
  logic                     s1_redirect;
  logic [dqc_pkg::CNT_AW-1:0] s1_addr;

  always_comb begin
    s1_verdict  = dqc_pkg::classify(s1_frame, query_port);
    // A queue outside the configured range counts as unbound
    s1_redirect = (s1_verdict == dqc_pkg::VERDICT_QUERY) &&
                  ({1'b0, s1_queue} < 7'(NUM_QUEUES)) &&
                  queue_bound_mask[s1_queue];
    s1_addr     = (s1_kind == dqc_pkg::KIND_COUNTER) ? s1_sel : s1_verdict + 3'd1;
  end

  // Stage 2: counter update and result assembly
  logic                       s2_valid;
  logic                       s2_kind;
  logic [2:0]                 s2_verdict;
  logic                       s2_redirect;
  logic [5:0]                 s2_queue;
  logic [dqc_pkg::CNT_AW-1:0] s2_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind     <= s1_kind;
      s2_verdict  <= s1_verdict;
      s2_redirect <= s1_redirect;
      s2_queue    <= s1_queue;
      s2_addr     <= s1_addr;
    end
  end

  logic [dqc_pkg::CNT_W-1:0]     ram_rdata;
  logic [dqc_pkg::CNT_W-1:0]     cnt_cur;
  logic [dqc_pkg::CNT_W-1:0]     cnt_inc;
  logic                          cnt_we;
  logic [dqc_pkg::CNT_DEPTH-1:0] cnt_written;
  logic                          fwd_valid;
  logic [dqc_pkg::CNT_AW-1:0]    fwd_addr;
  logic [dqc_pkg::CNT_W-1:0]     fwd_data;
  logic [dqc_pkg::CNT_W-1:0]     total_count;

  // Read enable follows the advance so a held stage keeps its read data
  dqc_ram #(
    .WIDTH (dqc_pkg::CNT_W),
    .DEPTH (dqc_pkg::CNT_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (s2_addr),
    .wdata (cnt_inc),
    .re    (en),
    .raddr (s1_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    // The write made in the cycle of this read is not in the RAM data yet
    if (fwd_valid && fwd_addr == s2_addr) cnt_cur = fwd_data;
    else if (cnt_written[s2_addr])       cnt_cur = ram_rdata;
    else                                 cnt_cur = '0;
    cnt_inc = cnt_cur + 64'd1;
    cnt_we  = en && s2_valid && (s2_kind == dqc_pkg::KIND_VERDICT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_written <= '0;
      fwd_valid   <= 1'b0;
      total_count <= '0;
    end else begin
      if (en) begin
        fwd_valid <= cnt_we;
      end
      if (cnt_we) begin
        cnt_written[s2_addr] <= 1'b1;
        total_count          <= total_count + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_addr <= s2_addr;
      fwd_data <= cnt_inc;
    end
  end

  // Output register
  dqc_pkg::out_item_t s2_result;

  always_comb begin
    s2_result = '0;
    if (s2_kind == dqc_pkg::KIND_COUNTER) begin
      s2_result.result_kind = dqc_pkg::KIND_COUNTER;
      if (s2_addr == dqc_pkg::CNT_TOTAL)     s2_result.counter_value = total_count;
      else if (s2_addr == dqc_pkg::CNT_NONE) s2_result.counter_value = '0;
      else                                   s2_result.counter_value = cnt_cur;
    end else begin
      s2_result.result_kind  = dqc_pkg::KIND_VERDICT;
      s2_result.verdict      = s2_verdict;
      s2_result.redirect     = s2_redirect;
      s2_result.target_queue = s2_queue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= s2_result;
    end
  end

endmodule

`default_nettype wire

[hdl/dqc_checker.sv]
// Port-level checks for the DNS query classifier, bound to its top level.
// Depends on dqc_pkg and on the port names of dns_query_packet_classifier.
`default_nettype none

module dqc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire dqc_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Never stall the input while the output register is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_read_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == dqc_pkg::KIND_COUNTER |->
      out_data.verdict == 3'd0 && !out_data.redirect && out_data.target_queue == 6'd0)
    else $error("counter result carries verdict fields");

  a_verdict_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == dqc_pkg::KIND_VERDICT |->
      out_data.verdict <= dqc_pkg::VERDICT_QUERY && out_data.counter_value == 64'd0)
    else $error("bad verdict result");

  a_redirect_query: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.redirect |->
      out_data.result_kind == dqc_pkg::KIND_VERDICT &&
      out_data.verdict == dqc_pkg::VERDICT_QUERY)
    else $error("redirect without query verdict");

endmodule

bind dns_query_packet_classifier dqc_checker u_dqc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
